[design/vertex_perspective_project_core_assert.svh]
// Assertion macros for the vertex projection block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef VERTEX_PERSPECTIVE_PROJECT_CORE_ASSERT_SVH
`define VERTEX_PERSPECTIVE_PROJECT_CORE_ASSERT_SVH

// Same-cycle implication.
`define VPP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vpp assertion failed");

// Next-cycle implication.
`define VPP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vpp assertion failed");

`endif

[design/vpp_pkg.sv]
// Package for the vertex projection block: widths, payload types, register codes.
// No dependencies.
`default_nettype none
package vpp_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int ROW_FIELD_W = 16;
   localparam int ROT_FRAC    = 14;
   localparam int SCALE_W     = 24;
   localparam int SCALE_FRAC  = 16;
   localparam int CLIP_W      = 32;
   localparam int NDC_W       = 24;
   localparam int NDC_FRAC    = 16;
   localparam int UN_W        = CLIP_W + NDC_FRAC;
   localparam int DIV_LAT     = NDC_W + 2;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = (2 * COORD_WIDTH > 48) ? 2 * COORD_WIDTH : 48;

   localparam logic signed [NDC_W-1:0] NDC_MINUS_ONE = -(NDC_W'(1) << NDC_FRAC);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_POS_XY  = 3'd0,
      CSR_CAM_POS_Z   = 3'd1,
      CSR_ROT_RIGHT   = 3'd2,
      CSR_ROT_UP      = 3'd3,
      CSR_ROT_FORWARD = 3'd4,
      CSR_PROJ_SCALE  = 3'd5,
      CSR_DEPTH_MUL   = 3'd6,
      CSR_DEPTH_OFF   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vert_x;
      logic signed [COORD_WIDTH-1:0] vert_y;
      logic signed [COORD_WIDTH-1:0] vert_z;
   } req_type;

   typedef struct packed {
      logic signed [CLIP_W-1:0] clip_x;
      logic signed [CLIP_W-1:0] clip_y;
      logic signed [CLIP_W-1:0] clip_z;
      logic signed [CLIP_W-1:0] clip_w;
      logic signed [NDC_W-1:0]  ndc_x;
      logic signed [NDC_W-1:0]  ndc_y;
      logic signed [NDC_W-1:0]  ndc_z;
      logic                     w_zero;
   } rsp_type;

   typedef struct packed {
      logic [CLIP_W-1:0] rem;
      logic [NDC_W-1:0]  low;
      logic [NDC_W-1:0]  quo;
      logic [CLIP_W-1:0] ud;
      logic              neg;
      logic              ovf;
   } div_stage_type;

endpackage
`default_nettype wire

[design/vpp_div.sv]
// Pipelined restoring divider: (num * 2^16) / den, rounded, saturated to NDC width.
// Depends on vpp_pkg. One quotient bit per stage.
`default_nettype none
module vpp_div (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [vpp_pkg::CLIP_W-1:0]   num,
   input  wire logic signed [vpp_pkg::CLIP_W-1:0]   den,
   output logic signed [vpp_pkg::NDC_W-1:0]         quo
);

   localparam int CW = vpp_pkg::CLIP_W;
   localparam int NW = vpp_pkg::NDC_W;

   vpp_pkg::div_stage_type stage_ff [0:NW];
   vpp_pkg::div_stage_type load_in;
   logic signed [NW-1:0]   quo_ff;
   logic signed [NW-1:0]   quo_in;

   function automatic vpp_pkg::div_stage_type div_step(input vpp_pkg::div_stage_type s);
      vpp_pkg::div_stage_type r;
      logic [CW:0] t;
      logic        ge;
      r  = s;
      t  = {s.rem, s.low[NW-1]};
      ge = (t >= {1'b0, s.ud});
      r.rem = ge ? CW'(t - {1'b0, s.ud}) : t[CW-1:0];
      r.low = {s.low[NW-2:0], 1'b0};
      r.quo = {s.quo[NW-2:0], ge};
      return r;
   endfunction

   always_comb begin
      logic [CW-1:0]                un_mag;
      logic [vpp_pkg::UN_W-1:0]     un;
      un_mag = num[CW-1] ? CW'(-num) : CW'(num);
      un     = {un_mag, {vpp_pkg::NDC_FRAC{1'b0}}};
      load_in.ud  = den[CW-1] ? CW'(-den) : CW'(den);
      load_in.rem = CW'(un[vpp_pkg::UN_W-1:NW]);
      load_in.low = un[NW-1:0];
      load_in.quo = '0;
      load_in.neg = num[CW-1] ^ den[CW-1];
      load_in.ovf = (CW'(un[vpp_pkg::UN_W-1:NW]) >= load_in.ud);
   end

   always_comb begin
      vpp_pkg::div_stage_type s;
      logic                   rnd;
      logic [NW:0]            qr;
      s   = stage_ff[NW];
      rnd = ({s.rem, 1'b0} >= {1'b0, s.ud});
      qr  = {1'b0, s.quo} + (NW + 1)'(rnd);
      if (s.neg) begin
         if (s.ovf || qr >= ((NW + 1)'(1) << (NW - 1))) begin
            quo_in = {1'b1, {(NW - 1){1'b0}}};
         end else begin
            quo_in = NW'(-qr);
         end
      end else begin
         if (s.ovf || qr > (((NW + 1)'(1) << (NW - 1)) - 1'b1)) begin
            quo_in = {1'b0, {(NW - 1){1'b1}}};
         end else begin
            quo_in = NW'(qr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= load_in;
         for (int i = 1; i <= NW; i++) begin
            stage_ff[i] <= div_step(stage_ff[i-1]);
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

[design/vertex_perspective_project_core.sv]
// Top level of the vertex perspective projection block.
// Depends on vpp_pkg and vpp_div.
//
// Usage: each item on the req channel is one world-space vertex (Q12.12).
// It is accepted when req_valid is high and req_stall is low. One result
// item per vertex leaves on the rsp channel, taken when rsp_valid is high and
// rsp_stall is low, carrying clip x/y/z/w (Q20.12) and NDC x/y/z (Q8.16).
// When clip w is zero, NDC is forced to (0, 0, -1) and w_zero is set.
// Throughput is one item per clock unless stalled. Five arithmetic stages
// (camera offset, rotation products, rotation sums, projection products,
// rounding and saturation) precede the 26-stage divider, which retires one
// quotient bit per stage across three parallel dividers. Camera and
// projection registers are written through the csr channel, which is always
// ready; the user must make writes only while the block is idle (not
// enforced). A synchronous reset empties the pipeline and loads the identity
// camera. When the receiver stalls a valid result, the whole pipeline holds
// and req_stall is raised in the same cycle; nothing is dropped or repeated.
`default_nettype none
module vertex_perspective_project_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire vpp_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output vpp_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [vpp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [vpp_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CW     = vpp_pkg::COORD_WIDTH;
   localparam int DIFF_W = CW + 1;
   localparam int PROD_W = DIFF_W + vpp_pkg::ROW_FIELD_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam int VIEW_W = SUM_W - vpp_pkg::ROT_FRAC;
   localparam int RF     = vpp_pkg::ROW_FIELD_W;
   localparam int SW     = vpp_pkg::SCALE_W;
   localparam int LAT    = vpp_pkg::DIV_LAT;

   localparam logic signed [SUM_W-1:0] ROT_HALF = SUM_W'(1) << (vpp_pkg::ROT_FRAC - 1);
   localparam logic signed [63:0] SCALE_HALF = 64'sd1 << (vpp_pkg::SCALE_FRAC - 1);
   localparam logic [47:0] ROW_ONE = 48'd1 << vpp_pkg::ROT_FRAC;

   // Configuration registers.
   logic [2*CW-1:0] cam_pos_xy_ff;
   logic [CW-1:0]   cam_pos_z_ff;
   logic [47:0]     rot_right_ff;
   logic [47:0]     rot_up_ff;
   logic [47:0]     rot_forward_ff;
   logic [47:0]     proj_scale_ff;
   logic [31:0]     depth_mul_ff;
   logic [31:0]     depth_off_ff;

   logic en;
   logic csr_we;

   // Pipeline valid bits.
   logic [4:0]     stage_v_ff;
   logic [LAT-1:0] div_v_ff;

   // Stage 1: offset from camera.
   logic signed [DIFF_W-1:0] diff_ff [3];
   // Stage 2: rotation products, [row][component].
   logic signed [PROD_W-1:0] prod_ff [3][3];
   // Stage 3: view x and y, clip w.
   logic signed [VIEW_W-1:0] view_x_ff;
   logic signed [VIEW_W-1:0] view_y_ff;
   logic signed [31:0]       cw3_ff;
   // Stage 4: projection products.
   logic signed [63:0]       px_ff;
   logic signed [63:0]       py_ff;
   logic signed [63:0]       pz_ff;
   logic signed [31:0]       cw4_ff;
   // Stage 5: clip-space values.
   vpp_pkg::rsp_type         clip_ff;
   vpp_pkg::rsp_type         side_ff [LAT];

   logic signed [vpp_pkg::NDC_W-1:0] ndc_x;
   logic signed [vpp_pkg::NDC_W-1:0] ndc_y;
   logic signed [vpp_pkg::NDC_W-1:0] ndc_z;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // The pipeline moves as one unit unless the result at its end is stalled.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_pos_xy_ff  <= '0;
         cam_pos_z_ff   <= '0;
         rot_right_ff   <= ROW_ONE;
         rot_up_ff      <= ROW_ONE << RF;
         rot_forward_ff <= ROW_ONE << (2 * RF);
         proj_scale_ff  <= (48'd1 << vpp_pkg::SCALE_FRAC)
                           | (48'd1 << (vpp_pkg::SCALE_FRAC + SW));
         depth_mul_ff   <= 32'd1 << vpp_pkg::SCALE_FRAC;
         depth_off_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vpp_pkg::CSR_CAM_POS_XY:  cam_pos_xy_ff  <= csr_data[2*CW-1:0];
            vpp_pkg::CSR_CAM_POS_Z:   cam_pos_z_ff   <= csr_data[CW-1:0];
            vpp_pkg::CSR_ROT_RIGHT:   rot_right_ff   <= csr_data[47:0];
            vpp_pkg::CSR_ROT_UP:      rot_up_ff      <= csr_data[47:0];
            vpp_pkg::CSR_ROT_FORWARD: rot_forward_ff <= csr_data[47:0];
            vpp_pkg::CSR_PROJ_SCALE:  proj_scale_ff  <= csr_data[47:0];
            vpp_pkg::CSR_DEPTH_MUL:   depth_mul_ff   <= csr_data[31:0];
            vpp_pkg::CSR_DEPTH_OFF:   depth_off_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
         div_v_ff   <= '0;
      end else if (en) begin
         stage_v_ff <= {stage_v_ff[3:0], req_valid};
         div_v_ff   <= {div_v_ff[LAT-2:0], stage_v_ff[4]};
      end
   end

   always_ff @(posedge clock) begin
      logic [47:0]              rows [3];
      logic signed [SUM_W-1:0]  sum;
      logic signed [VIEW_W-1:0] view [3];
      logic signed [63:0]       zsum;
      if (en) begin
         // Stage 1.
         diff_ff[0] <= DIFF_W'(req_data.vert_x) - DIFF_W'($signed(cam_pos_xy_ff[CW-1:0]));
         diff_ff[1] <= DIFF_W'(req_data.vert_y)
                       - DIFF_W'($signed(cam_pos_xy_ff[2*CW-1:CW]));
         diff_ff[2] <= DIFF_W'(req_data.vert_z) - DIFF_W'($signed(cam_pos_z_ff));

         // Stage 2: operands are sign-extended so the product is exact.
         rows[0] = rot_right_ff;
         rows[1] = rot_up_ff;
         rows[2] = rot_forward_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PROD_W'($signed(rows[r][c*RF +: RF])) * PROD_W'(diff_ff[c]);
            end
         end

         // Stage 3: sum, then round half up on the rotation fraction.
         for (int r = 0; r < 3; r++) begin
            sum = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2])
                  + ROT_HALF;
            view[r] = sum[SUM_W-1:vpp_pkg::ROT_FRAC];
         end
         view_x_ff <= view[0];
         view_y_ff <= view[1];
         cw3_ff    <= sat32(64'(view[2]));

         // Stage 4.
         px_ff  <= 64'(view_x_ff) * 64'($signed({1'b0, proj_scale_ff[SW-1:0]}));
         py_ff  <= 64'(view_y_ff) * 64'($signed({1'b0, proj_scale_ff[2*SW-1:SW]}));
         pz_ff  <= 64'($signed(depth_mul_ff)) * 64'(cw3_ff);
         cw4_ff <= cw3_ff;

         // Stage 5: depth offset, rounding and saturation.
         zsum = pz_ff - (64'($signed(depth_off_ff)) <<< 12) + SCALE_HALF;
         clip_ff.clip_x <= sat32((px_ff + SCALE_HALF) >>> vpp_pkg::SCALE_FRAC);
         clip_ff.clip_y <= sat32((py_ff + SCALE_HALF) >>> vpp_pkg::SCALE_FRAC);
         clip_ff.clip_z <= sat32(zsum >>> vpp_pkg::SCALE_FRAC);
         clip_ff.clip_w <= cw4_ff;
         clip_ff.ndc_x  <= '0;
         clip_ff.ndc_y  <= '0;
         clip_ff.ndc_z  <= '0;
         clip_ff.w_zero <= (cw4_ff == '0);

         // Clip values travel alongside the dividers.
         side_ff[0] <= clip_ff;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   vpp_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (clip_ff.clip_x),
      .den   (clip_ff.clip_w),
      .quo   (ndc_x)
   );

   vpp_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (clip_ff.clip_y),
      .den   (clip_ff.clip_w),
      .quo   (ndc_y)
   );

   vpp_div u_div_z (
      .clock (clock),
      .en    (en),
      .num   (clip_ff.clip_z),
      .den   (clip_ff.clip_w),
      .quo   (ndc_z)
   );

   // Zero depth overrides the divider outputs.
   always_comb begin
      rsp_data = side_ff[LAT-1];
      if (side_ff[LAT-1].w_zero) begin
         rsp_data.ndc_x = '0;
         rsp_data.ndc_y = '0;
         rsp_data.ndc_z = vpp_pkg::NDC_MINUS_ONE;
      end else begin
         rsp_data.ndc_x = ndc_x;
         rsp_data.ndc_y = ndc_y;
         rsp_data.ndc_z = ndc_z;
      end
   end

   assign rsp_valid = div_v_ff[LAT-1];

endmodule
`default_nettype wire

[design/vpp_checker.sv]
// Port-level checker for the vertex projection block, with its bind.
// Depends on vpp_pkg and vertex_perspective_project_core_assert.svh.
`default_nettype none
`include "vertex_perspective_project_core_assert.svh"
module vpp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire vpp_pkg::rsp_type rsp_data
);

   logic ndc_forced;

   assign ndc_forced = (rsp_data.ndc_x == '0) && (rsp_data.ndc_y == '0)
                       && (rsp_data.ndc_z == vpp_pkg::NDC_MINUS_ONE);

   `VPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, $stable(rsp_data))
   `VPP_ASSERT_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall)
   `VPP_ASSERT_NOW(a_wzero_flag, rsp_valid, rsp_data.w_zero == (rsp_data.clip_w == 0))
   `VPP_ASSERT_NOW(a_wzero_ndc, rsp_valid && rsp_data.w_zero, ndc_forced)

endmodule

bind vertex_perspective_project_core vpp_checker u_vpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

[sim/tb_vertex_perspective_project_core.sv]
// Self-checking testbench for vertex_perspective_project_core.
// Depends on vpp_pkg and the block's RTL; predicts every projected vertex in place.
`default_nettype none
module tb_vertex_perspective_project_core;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vpp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vpp_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vpp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [vpp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   vertex_perspective_project_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Quiet time used at the end of a phase before a register is rewritten.
   localparam int PIPE_DRAIN = 40;
   localparam int CYCLE_LIMIT = 400000;

   // Shadow copy of the camera and projection registers.
   logic [47:0] cam_xy, right_row, up_row, fwd_row, scale_xy;
   logic [23:0] cam_z;
   logic [31:0] dmul, doff;

   vpp_pkg::rsp_type projected_q[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit calm = 1'b0;   // when set, neither side idles

   // Division by 2^s of a signed value with half-up rounding, as the datapath
   // uses for the rotation and scale stages.
   function automatic longint round_up_shift(longint v, int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint dot_row(logic [47:0] row, longint dx, longint dy, longint dz);
      longint r0, r1, r2;
      r0 = longint'($signed(row[15:0]));
      r1 = longint'($signed(row[31:16]));
      r2 = longint'($signed(row[47:32]));
      return round_up_shift(r0 * dx + r1 * dy + r2 * dz, vpp_pkg::ROT_FRAC);
   endfunction

   // Rounded (n * 2^16) / d with ties away from zero, saturated to NDC width.
   function automatic longint ndc_quotient(longint n, longint d);
      longint num, q, r;
      bit neg;
      logic [63:0] un, ud;
      num = n * 65536;
      neg = (num < 0) != (d < 0);
      un = (num < 0) ? -num : num;
      ud = (d < 0) ? -d : d;
      q = longint'((2 * un + ud) / (2 * ud));
      r = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
      return clamp(neg ? -r : r, vpp_pkg::NDC_W);
   endfunction

   function automatic vpp_pkg::rsp_type project_vertex(vpp_pkg::req_type v);
      vpp_pkg::rsp_type p;
      longint dx, dy, dz, vx, vy, vz, sx, sy, cx, cy, cz, cw;
      dx = longint'(v.vert_x) - longint'($signed(cam_xy[23:0]));
      dy = longint'(v.vert_y) - longint'($signed(cam_xy[47:24]));
      dz = longint'(v.vert_z) - longint'($signed(cam_z));
      vx = dot_row(right_row, dx, dy, dz);
      vy = dot_row(up_row, dx, dy, dz);
      vz = dot_row(fwd_row, dx, dy, dz);
      sx = longint'(scale_xy[23:0]);
      sy = longint'(scale_xy[47:24]);
      cw = clamp(vz, vpp_pkg::CLIP_W);
      cx = clamp(round_up_shift(vx * sx, vpp_pkg::SCALE_FRAC), vpp_pkg::CLIP_W);
      cy = clamp(round_up_shift(vy * sy, vpp_pkg::SCALE_FRAC), vpp_pkg::CLIP_W);
      cz = clamp(round_up_shift(longint'($signed(dmul)) * cw
                 - longint'($signed(doff)) * 4096, vpp_pkg::SCALE_FRAC), vpp_pkg::CLIP_W);
      p.clip_x = cx[31:0];
      p.clip_y = cy[31:0];
      p.clip_z = cz[31:0];
      p.clip_w = cw[31:0];
      if (cw == 0) begin
         // Zero depth: NDC is pinned to (0, 0, -1) and the flag is raised.
         p.ndc_x = '0;
         p.ndc_y = '0;
         p.ndc_z = vpp_pkg::NDC_MINUS_ONE;
         p.w_zero = 1'b1;
      end else begin
         p.ndc_x = vpp_pkg::NDC_W'(ndc_quotient(cx, cw));
         p.ndc_y = vpp_pkg::NDC_W'(ndc_quotient(cy, cw));
         p.ndc_z = vpp_pkg::NDC_W'(ndc_quotient(cz, cw));
         p.w_zero = 1'b0;
      end
      return p;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 18);
   endfunction

   // Appends one prediction at the tail of the expectation queue.
   task automatic queue_projection(vpp_pkg::rsp_type p);
      projected_q = {projected_q, p};
   endtask

   // Result checker: receiver stalls at random and compares each taken item.
   always @(posedge clock) begin
      vpp_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (projected_q.size() == 0) begin
               $error("unexpected result item %h", rsp_data);
               fail_count = fail_count + 1;
            end else begin
               want = projected_q.pop_front();
               if (rsp_data.clip_x !== want.clip_x) begin
                  $error("clip_x expected %h got %h", want.clip_x, rsp_data.clip_x);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.clip_y !== want.clip_y) begin
                  $error("clip_y expected %h got %h", want.clip_y, rsp_data.clip_y);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.clip_z !== want.clip_z) begin
                  $error("clip_z expected %h got %h", want.clip_z, rsp_data.clip_z);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.clip_w !== want.clip_w) begin
                  $error("clip_w expected %h got %h", want.clip_w, rsp_data.clip_w);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.ndc_x !== want.ndc_x) begin
                  $error("ndc_x expected %h got %h", want.ndc_x, rsp_data.ndc_x);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.ndc_y !== want.ndc_y) begin
                  $error("ndc_y expected %h got %h", want.ndc_y, rsp_data.ndc_y);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.ndc_z !== want.ndc_z) begin
                  $error("ndc_z expected %h got %h", want.ndc_z, rsp_data.ndc_z);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.w_zero !== want.w_zero) begin
                  $error("w_zero expected %b got %b", want.w_zero, rsp_data.w_zero);
                  fail_count = fail_count + 1;
               end
            end
         end
         rsp_stall <= idle_now();
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vertex_perspective_project_core regression: fail");
         $finish;
      end
   end

   // Send one vertex; the expectation is queued at the accepting edge.
   // Valid stays high after the item so that back-to-back items leave no gap.
   task automatic send_vertex(vpp_pkg::req_type v);
      if (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (idle_now()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_projection(project_vertex(v));
   endtask

   task automatic send_xyz(longint x, longint y, longint z);
      vpp_pkg::req_type v;
      v.vert_x = x[23:0];
      v.vert_y = y[23:0];
      v.vert_z = z[23:0];
      send_vertex(v);
   endtask

   task automatic send_random_vertex(int span);
      vpp_pkg::req_type v;
      v.vert_x = (span == 0) ? 24'($urandom) : 24'($signed(24'($urandom_range(2 * span))) - span);
      v.vert_y = (span == 0) ? 24'($urandom) : 24'($signed(24'($urandom_range(2 * span))) - span);
      v.vert_z = (span == 0) ? 24'($urandom) : 24'($signed(24'($urandom_range(2 * span))) - span);
      send_vertex(v);
   endtask

   // Stops sending and waits until every expected result is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (projected_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // Register write; the shadow copy changes at the same edge as the block's.
   task automatic write_reg(vpp_pkg::csr_index_type idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         vpp_pkg::CSR_CAM_POS_XY:  cam_xy = val;
         vpp_pkg::CSR_CAM_POS_Z:   cam_z = val[23:0];
         vpp_pkg::CSR_ROT_RIGHT:   right_row = val;
         vpp_pkg::CSR_ROT_UP:      up_row = val;
         vpp_pkg::CSR_ROT_FORWARD: fwd_row = val;
         vpp_pkg::CSR_PROJ_SCALE:  scale_xy = val;
         vpp_pkg::CSR_DEPTH_MUL:   dmul = val[31:0];
         vpp_pkg::CSR_DEPTH_OFF:   doff = val[31:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A random camera: full-range rotation entries, moderate scales.
   task automatic load_random_camera();
      write_reg(vpp_pkg::CSR_CAM_POS_XY, {24'($signed(24'($urandom_range(65536))) - 32768),
                                          24'($signed(24'($urandom_range(65536))) - 32768)});
      write_reg(vpp_pkg::CSR_CAM_POS_Z, 48'($urandom_range(65536)) - 48'd32768);
      write_reg(vpp_pkg::CSR_ROT_RIGHT, 48'({$urandom, $urandom}));
      write_reg(vpp_pkg::CSR_ROT_UP, 48'({$urandom, $urandom}));
      write_reg(vpp_pkg::CSR_ROT_FORWARD, 48'({$urandom, $urandom}));
      write_reg(vpp_pkg::CSR_PROJ_SCALE, {24'($urandom_range(262144)),
                                          24'($urandom_range(262144))});
      write_reg(vpp_pkg::CSR_DEPTH_MUL, 48'($signed($urandom_range(262144)) - 131072));
      write_reg(vpp_pkg::CSR_DEPTH_OFF, 48'($signed($urandom_range(262144)) - 131072));
   endtask

   // Reset defaults: identity camera at the origin, unit scales.
   task automatic test_reset_identity();
      send_xyz(0, 0, 0);
      send_xyz(4096, -4096, 4096);
      send_xyz(8388607, 8388607, 8388607);
      send_xyz(-8388608, -8388608, -8388608);
      send_xyz(1, -1, 1);
      send_xyz(12345, 0, -1);
      wait_drained();
   endtask

   // Extremes of every register with the extreme vertices.
   task automatic test_register_extremes();
      write_reg(vpp_pkg::CSR_CAM_POS_XY, {24'h7fffff, 24'h800000});
      write_reg(vpp_pkg::CSR_CAM_POS_Z, 48'h800000);
      write_reg(vpp_pkg::CSR_ROT_RIGHT, {16'h7fff, 16'h8000, 16'h7fff});
      write_reg(vpp_pkg::CSR_ROT_UP, {16'h8000, 16'h8000, 16'h8000});
      write_reg(vpp_pkg::CSR_ROT_FORWARD, {16'h7fff, 16'h7fff, 16'h7fff});
      write_reg(vpp_pkg::CSR_PROJ_SCALE, 48'hffffff_ffffff);
      write_reg(vpp_pkg::CSR_DEPTH_MUL, 48'h7fffffff);
      write_reg(vpp_pkg::CSR_DEPTH_OFF, 48'h80000000);
      send_xyz(8388607, 8388607, 8388607);   // large view depth
      send_xyz(-8388608, -8388608, -8388608);
      send_xyz(8388607, -8388608, 8388607);
      send_xyz(0, 0, 0);
      wait_drained();
      // Zero projection scale and opposite depth factors.
      write_reg(vpp_pkg::CSR_PROJ_SCALE, 48'h0);
      write_reg(vpp_pkg::CSR_DEPTH_MUL, 48'h80000000);
      write_reg(vpp_pkg::CSR_DEPTH_OFF, 48'h7fffffff);
      send_xyz(-8388608, 8388607, -8388608);
      send_xyz(100, 200, 300);
      wait_drained();
   endtask

   // Zero depth: camera on the vertex plane gives w of zero.
   task automatic test_zero_depth();
      write_reg(vpp_pkg::CSR_CAM_POS_XY, 48'h0);
      write_reg(vpp_pkg::CSR_CAM_POS_Z, 48'h1000);
      write_reg(vpp_pkg::CSR_ROT_RIGHT, 48'h4000);
      write_reg(vpp_pkg::CSR_ROT_UP, 48'h4000_0000);
      write_reg(vpp_pkg::CSR_ROT_FORWARD, 48'h4000_0000_0000);
      write_reg(vpp_pkg::CSR_PROJ_SCALE, 48'h010000_010000);
      write_reg(vpp_pkg::CSR_DEPTH_MUL, 48'h10000);
      write_reg(vpp_pkg::CSR_DEPTH_OFF, 48'h0);
      send_xyz(4096, -4096, 4096);
      send_xyz(-8388608, 8388607, 4096);
      send_xyz(0, 0, 4097);    // tiny positive depth
      send_xyz(8388607, 0, 4095);
      wait_drained();
   endtask

   // Random vertices under several random cameras; a calm stretch included.
   task automatic test_random_cameras();
      for (int phase = 0; phase < 10; phase++) begin
         load_random_camera();
         calm = (phase == 3);
         for (int n = 0; n < 110; n++) begin
            // Midway through one phase the sender holds off until every
            // projection is back.
            if (phase == 5 && n == 55) wait_drained();
            send_random_vertex(($urandom_range(3) == 0) ? 0 : 65536);
         end
         calm = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      cam_xy = '0;
      cam_z = '0;
      right_row = 48'd16384;
      up_row = 48'd1073741824;
      fwd_row = 48'd70368744177664;
      scale_xy = 48'd1099511693312;
      dmul = 32'd65536;
      doff = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_identity();
      test_register_extremes();
      test_zero_depth();
      test_random_cameras();
      if (fail_count == 0) begin
         $display("vertex_perspective_project_core regression: pass");
      end else begin
         $display("vertex_perspective_project_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
+incdir+design
design/vpp_pkg.sv
design/vpp_div.sv
design/vertex_perspective_project_core.sv
design/vpp_checker.sv
sim/tb_vertex_perspective_project_core.sv
